[hw/rtl/hrhp_pkg.sv]
// Package for the HTTP request head parser: parser state type, result type,
// phase codes and the byte-level update functions. No dependencies.
`timescale 1ns / 1ps

package hrhp_pkg;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_SLASH   = 3'd1,
        PH_PATH    = 3'd2,
        PH_VERSION = 3'd3,
        PH_NAME    = 3'd4,
        PH_SKIP    = 3'd5,
        PH_VALUE   = 3'd6,
        PH_TRAIL   = 3'd7
    } phase_t;

    localparam logic [1:0] KIND_PATH = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    localparam logic [1:0] METH_GET     = 2'd0;
    localparam logic [1:0] METH_HEAD    = 2'd1;
    localparam logic [1:0] METH_UNKNOWN = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [3:0] POS_MAX = 4'd15;
    localparam logic [3:0] VER_LEN = 4'd9;
    localparam logic [2:0] CLOSE_LEN = 3'd5;
    localparam logic [2:0] CLOSE_FAIL = 3'd6;

    // Content-length digit tracking.
    localparam logic [1:0] LD_NONE = 2'd0;
    localparam logic [1:0] LD_ZERO = 2'd1;
    localparam logic [1:0] LD_POS  = 2'd2;
    localparam logic [1:0] LD_BAD  = 2'd3;

    localparam logic [8*16-1:0] TXT_CONNECTION = "connection";
    localparam logic [8*16-1:0] TXT_CTYPE      = "content-type";
    localparam logic [8*16-1:0] TXT_CLENGTH    = "content-length";
    localparam logic [8*16-1:0] TXT_SERVER     = "server";
    localparam logic [8*16-1:0] TXT_VERSION    = "HTTP/1.1\r";
    localparam logic [8*16-1:0] TXT_GET        = "GET";
    localparam logic [8*16-1:0] TXT_HEAD       = "HEAD";
    localparam logic [8*16-1:0] TXT_CLOSE      = "close";

    typedef struct packed {
        phase_t     phase;
        logic [3:0] pos;
        logic [3:0] cand;
        logic [1:0] mcand;
        logic [3:0] seen;
        logic [2:0] cmatch;
        logic [1:0] ldig;
        logic       lerr;
        logic       pok;
        logic [1:0] mheld;
    } pstate_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] path_byte;
        logic [1:0] method_code;
        logic       path_valid;
        logic       close_requested;
        logic [1:0] error_cause;
    } result_t;

    localparam pstate_t PSTATE_CLEAR = '{
        phase: PH_METHOD, pos: 4'd0, cand: 4'hF, mcand: 2'b11, seen: 4'h0,
        cmatch: 3'd0, ldig: LD_NONE, lerr: 1'b0, pok: 1'b1, mheld: METH_UNKNOWN
    };

    // Character at position pos of a string of length len (text right-aligned).
    function automatic logic [7:0] text_char(logic [8*16-1:0] s, logic [3:0] len,
                                             logic [3:0] pos);
        logic [8*16-1:0] sh;
        sh = s >> (8 * (len - 4'd1 - pos));
        return sh[7:0];
    endfunction

    function automatic logic text_hit(logic [8*16-1:0] s, logic [3:0] len,
                                      logic [3:0] pos, logic [7:0] b);
        return (pos < len) && (b == text_char(s, len, pos));
    endfunction

    function automatic logic [3:0] hdr_len(int k);
        case (k)
            0: return 4'd10;
            1: return 4'd12;
            2: return 4'd14;
            default: return 4'd6;
        endcase
    endfunction

    function automatic logic [8*16-1:0] hdr_text(int k);
        case (k)
            0: return TXT_CONNECTION;
            1: return TXT_CTYPE;
            2: return TXT_CLENGTH;
            default: return TXT_SERVER;
        endcase
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic path_char_ok(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || is_digit(b) ||
               b == "-" || b == "/" || b == ".";
    endfunction

    function automatic pstate_t value_char(pstate_t st, logic [7:0] b);
        pstate_t r;
        r = st;
        if (st.cand[0]) begin
            if (st.cmatch < CLOSE_LEN && text_hit(TXT_CLOSE, 4'd5, {1'b0, st.cmatch}, b))
                r.cmatch = st.cmatch + 3'd1;
            else
                r.cmatch = CLOSE_FAIL;
        end
        if (st.cand[2]) begin
            if (!is_digit(b)) r.ldig = LD_BAD;
            else if (st.ldig != LD_BAD) begin
                if (b != "0") r.ldig = LD_POS;
                else if (st.ldig == LD_NONE) r.ldig = LD_ZERO;
            end
        end
        return r;
    endfunction

    // One byte of a header line (never the ending CR LF).
    function automatic pstate_t header_byte(pstate_t st, logic [7:0] b);
        pstate_t r;
        logic [3:0] found;
        logic [7:0] lower;
        r = st;
        found = 4'h0;
        lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (!st.lerr) begin
            case (st.phase)
                PH_NAME: begin
                    if (b == CH_COLON) begin
                        if (st.pos == 4'd0) begin
                            r.lerr = 1'b1;
                        end else begin
                            for (int k = 0; k < 4; k++)
                                if (st.cand[k] && st.pos == hdr_len(k)) found = 4'h1 << k;
                            r.cand = found;
                            if (found[0]) r.cmatch = 3'd0;
                            if (found[2]) r.ldig = LD_NONE;
                            r.phase = PH_SKIP;
                        end
                    end else begin
                        for (int k = 0; k < 4; k++)
                            if (!text_hit(hdr_text(k), hdr_len(k), st.pos, lower))
                                r.cand[k] = 1'b0;
                        if (st.pos < POS_MAX) r.pos = st.pos + 4'd1;
                    end
                end
                PH_SKIP: begin
                    if (b != CH_SPACE) begin
                        r = value_char(st, b);
                        r.phase = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (b == CH_SPACE) r.phase = PH_TRAIL;
                    else r = value_char(st, b);
                end
                default: begin
                    if (b != CH_SPACE) r.lerr = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

endpackage

[hw/rtl/hrhp_step.sv]
// Combinational next-state and result logic for one request byte.
// Depends on hrhp_pkg.
`timescale 1ns / 1ps

module hrhp_step #(
    parameter int LINE_COUNTER_BITS = 16
) (
    input  hrhp_pkg::pstate_t              st_in,
    input  logic                           lwc_in,
    input  logic [LINE_COUNTER_BITS-1:0]   lb_in,
    input  logic [7:0]                     data_byte,
    input  logic                           new_connection,
    input  logic [15:0]                    line_limit,
    output hrhp_pkg::pstate_t              st_out,
    output logic                           lwc_out,
    output logic [LINE_COUNTER_BITS-1:0]   lb_out,
    output logic                           emit,
    output hrhp_pkg::result_t              res
);
    import hrhp_pkg::*;

    localparam int CW = (LINE_COUNTER_BITS > 16) ? LINE_COUNTER_BITS : 16;

    pstate_t                      st;
    logic                         lwc;
    logic [LINE_COUNTER_BITS-1:0] lb;
    logic [CW-1:0]                lb_wide;
    logic [CW-1:0]                max_wide;

    always_comb begin
        st = st_in;
        lwc = lwc_in;
        lb = lb_in;
        emit = 1'b0;
        res = '0;
        lb_wide = '0;
        max_wide = CW'(line_limit);
        if (new_connection) begin
            st = PSTATE_CLEAR;
            lwc = 1'b0;
            lb = '0;
        end
        if (lwc && data_byte == CH_LF) begin
            // End of line: check what the line left behind.
            lwc = 1'b0;
            lb = '0;
            emit = 1'b1;
            res.kind = KIND_BAD;
            res.error_cause = ERR_MALFORMED;
            if (!st.lerr) begin
                case (st.phase)
                    PH_VERSION: begin
                        if (st.pos == VER_LEN) emit = 1'b0;
                    end
                    PH_NAME: begin
                        if (st.pos == 4'd0) begin
                            res.kind = KIND_DONE;
                            res.error_cause = ERR_NONE;
                            res.method_code = st.mheld;
                            res.path_valid = st.pok;
                            res.close_requested = st.seen[0] && st.cmatch == CLOSE_LEN;
                        end
                    end
                    PH_VALUE, PH_TRAIL: begin
                        if (!(|(st.cand & st.seen)) && !(st.cand[2] && st.ldig != LD_ZERO)) begin
                            emit = 1'b0;
                            st.seen = st.seen | st.cand;
                        end
                    end
                    default: ;
                endcase
            end
            if (emit) begin
                st = PSTATE_CLEAR;
            end else begin
                st.phase = PH_NAME;
                st.pos = 4'd0;
                st.cand = 4'hF;
            end
        end else begin
            if (lb != {LINE_COUNTER_BITS{1'b1}}) lb = lb + 1'b1;
            lb_wide = CW'(lb);
            if (lb_wide > max_wide) begin
                emit = 1'b1;
                res.kind = KIND_BAD;
                res.error_cause = ERR_TOO_LONG;
                st = PSTATE_CLEAR;
                lwc = 1'b0;
                lb = '0;
            end else if (st.phase >= PH_NAME) begin
                // A CR held back from the previous byte was an ordinary byte.
                if (lwc) begin
                    lwc = 1'b0;
                    st = header_byte(st, CH_CR);
                end
                if (data_byte == CH_CR) lwc = 1'b1;
                else st = header_byte(st, data_byte);
            end else begin
                lwc = (data_byte == CH_CR);
                if (!st.lerr) begin
                    case (st.phase)
                        PH_METHOD: begin
                            if (data_byte == CH_SPACE) begin
                                if (st.pos == 4'd0) begin
                                    st.lerr = 1'b1;
                                end else begin
                                    if (st.mcand[0] && st.pos == 4'd3) st.mheld = METH_GET;
                                    else if (st.mcand[1] && st.pos == 4'd4)
                                        st.mheld = METH_HEAD;
                                    else st.mheld = METH_UNKNOWN;
                                    st.phase = PH_SLASH;
                                end
                            end else begin
                                if (!text_hit(TXT_GET, 4'd3, st.pos, data_byte))
                                    st.mcand[0] = 1'b0;
                                if (!text_hit(TXT_HEAD, 4'd4, st.pos, data_byte))
                                    st.mcand[1] = 1'b0;
                                if (st.pos < POS_MAX) st.pos = st.pos + 4'd1;
                            end
                        end
                        PH_SLASH: begin
                            if (data_byte != CH_SLASH) begin
                                st.lerr = 1'b1;
                            end else begin
                                st.phase = PH_PATH;
                                emit = 1'b1;
                            end
                        end
                        PH_PATH: begin
                            if (data_byte == CH_SPACE) begin
                                st.phase = PH_VERSION;
                                st.pos = 4'd0;
                            end else begin
                                if (!path_char_ok(data_byte)) st.pok = 1'b0;
                                emit = 1'b1;
                            end
                        end
                        default: begin
                            if (st.pos < VER_LEN && text_hit(TXT_VERSION, VER_LEN, st.pos,
                                                             data_byte))
                                st.pos = st.pos + 4'd1;
                            else
                                st.lerr = 1'b1;
                        end
                    endcase
                    if (emit) begin
                        res.kind = KIND_PATH;
                        res.path_byte = data_byte;
                        res.method_code = st.mheld;
                        res.path_valid = st.pok;
                    end
                end
            end
        end
        st_out = st;
        lwc_out = lwc;
        lb_out = lb;
    end

endmodule

[hw/rtl/http_request_head_parser.sv]
// HTTP/1.1 request head parser top level: parser state registers, line
// length register and result register. Depends on hrhp_pkg and hrhp_step.
// A result is registered and appears on m_* in the cycle after the request byte is taken.
// Throughput: one byte per cycle while s_tready is high; the state update is combinational.
// s_tready stays high while the result register is empty or being drained.
// Reset (aresetn low, synchronous) clears the parser and sets max length 8192.
`timescale 1ns / 1ps

module http_request_head_parser #(
    parameter int LINE_COUNTER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // longest allowed line in bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] data_byte
    input  logic        s_tuser,      // [0] new_connection
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] path_byte, [9:8] method_code, [10] path_valid,
    // [11] close_requested, [13:12] error_cause, [15:14] zero
    output logic [15:0] m_tdata,
    output logic [1:0]  m_tuser       // [1:0] kind
);
    import hrhp_pkg::*;

    pstate_t                      st_reg, st_next;
    logic                         lwc_reg, lwc_next;
    logic [LINE_COUNTER_BITS-1:0] lb_reg, lb_next;
    logic [15:0]                  max_len_reg;
    logic                         m_valid_reg;
    result_t                      res_reg, res_next;
    logic                         emit;
    logic                         accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    hrhp_step #(
        .LINE_COUNTER_BITS(LINE_COUNTER_BITS)
    ) u_step (
        .st_in           (st_reg),
        .lwc_in          (lwc_reg),
        .lb_in           (lb_reg),
        .data_byte       (s_tdata),
        .new_connection  (s_tuser),
        .line_limit      (max_len_reg),
        .st_out          (st_next),
        .lwc_out         (lwc_next),
        .lb_out          (lb_next),
        .emit            (emit),
        .res             (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= PSTATE_CLEAR;
            lwc_reg     <= 1'b0;
            lb_reg      <= '0;
            max_len_reg <= 16'd8192;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) max_len_reg <= cfg_wr_data;
            if (accept) begin
                st_reg      <= st_next;
                lwc_reg     <= lwc_next;
                lb_reg      <= lb_next;
                m_valid_reg <= emit;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) res_reg <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {2'b00, res_reg.error_cause, res_reg.close_requested,
                       res_reg.path_valid, res_reg.method_code, res_reg.path_byte};

endmodule

[tb/tb.sv]
// Self-checking testbench for the HTTP request head parser: drives request
// bytes over the s_ stream and checks kind and result fields on the m_ stream.
// Depends on hrhp_pkg (codes and types) and http_request_head_parser.
`timescale 1ns / 1ps

module tb;
    import hrhp_pkg::*;

    typedef struct {
        logic [7:0] data_byte;
        logic       new_conn;
        logic       has_fixed;
        logic [1:0] fixed_kind;
        logic [1:0] fixed_err;
    } stim_row_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] path_byte;
        logic [1:0] method_code;
        logic       path_valid;
        logic       close_requested;
        logic [1:0] error_cause;
    } parse_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    http_request_head_parser u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Parser state mirror.
    int unsigned   line_limit;
    logic [2:0]    phase;
    logic [3:0]    pos, cand, seen;
    logic [1:0]    mcand, ldig, mheld;
    logic [2:0]    cmatch;
    logic          lerr, pok, prev_cr;
    int unsigned   line_count;

    parse_result_t expected_results[$];
    int            error_count = 0;
    longint        cycle_count = 0;
    bit            no_idle = 0;
    bit            hold_sink = 0;

    string txt_hdr[4] = '{"connection", "content-type", "content-length", "server"};
    string txt_ver = "HTTP/1.1\r";

    function automatic void clear_parse();
        phase = PH_METHOD; pos = 0; cand = 4'hF; mcand = 2'b11; seen = 0;
        cmatch = 0; ldig = LD_NONE; line_count = 0; prev_cr = 0; lerr = 0;
        pok = 1; mheld = METH_UNKNOWN;
    endfunction

    function automatic void push_bad(logic [1:0] cause);
        parse_result_t r;
        clear_parse();
        r = '0; r.kind = KIND_BAD; r.error_cause = cause;
        expected_results.push_back(r);
    endfunction

    function automatic void push_path(logic [7:0] b);
        parse_result_t r;
        r = '0; r.kind = KIND_PATH; r.path_byte = b; r.method_code = mheld;
        r.path_valid = pok;
        expected_results.push_back(r);
    endfunction

    function automatic bit ok_path_char(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9") || b == "-" || b == "/" || b == ".";
    endfunction

    function automatic void value_track(logic [7:0] b);
        string cl;
        cl = "close";
        if (cand[0]) begin
            if (cmatch < 5 && b == cl[cmatch]) cmatch++;
            else cmatch = CLOSE_FAIL;
        end
        if (cand[2]) begin
            if (b < "0" || b > "9") ldig = LD_BAD;
            else if (ldig != LD_BAD) begin
                if (b != "0") ldig = LD_POS;
                else if (ldig == LD_NONE) ldig = LD_ZERO;
            end
        end
    endfunction

    function automatic void track_header(logic [7:0] b);
        logic [7:0] lower;
        logic [3:0] found;
        if (lerr) return;
        case (phase)
            PH_NAME: begin
                if (b == CH_COLON) begin
                    if (pos == 0) begin
                        lerr = 1;
                        return;
                    end
                    found = 0;
                    for (int k = 0; k < 4; k++)
                        if (cand[k] && pos == txt_hdr[k].len()) found = 4'h1 << k;
                    cand = found;
                    if (found[0]) cmatch = 0;
                    if (found[2]) ldig = LD_NONE;
                    phase = PH_SKIP;
                end else begin
                    lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                    for (int k = 0; k < 4; k++)
                        if (!(pos < txt_hdr[k].len() && lower == txt_hdr[k][pos]))
                            cand[k] = 0;
                    if (pos < 15) pos++;
                end
            end
            PH_SKIP: begin
                if (b != CH_SPACE) begin
                    phase = PH_VALUE;
                    value_track(b);
                end
            end
            PH_VALUE: begin
                if (b == CH_SPACE) phase = PH_TRAIL;
                else value_track(b);
            end
            default: begin
                if (b != CH_SPACE) lerr = 1;
            end
        endcase
    endfunction

    function automatic void track_start(logic [7:0] b);
        string gt, hd;
        gt = "GET"; hd = "HEAD";
        if (lerr) return;
        case (phase)
            PH_METHOD: begin
                if (b == CH_SPACE) begin
                    if (pos == 0) begin
                        lerr = 1;
                        return;
                    end
                    if (mcand[0] && pos == 3) mheld = METH_GET;
                    else if (mcand[1] && pos == 4) mheld = METH_HEAD;
                    else mheld = METH_UNKNOWN;
                    phase = PH_SLASH;
                end else begin
                    if (!(pos < 3 && b == gt[pos])) mcand[0] = 0;
                    if (!(pos < 4 && b == hd[pos])) mcand[1] = 0;
                    if (pos < 15) pos++;
                end
            end
            PH_SLASH: begin
                if (b != CH_SLASH) begin
                    lerr = 1;
                    return;
                end
                phase = PH_PATH;
                push_path(b);
            end
            PH_PATH: begin
                if (b == CH_SPACE) begin
                    phase = PH_VERSION;
                    pos = 0;
                    return;
                end
                if (!ok_path_char(b)) pok = 0;
                push_path(b);
            end
            default: begin
                if (pos < 9 && b == txt_ver[pos]) pos++;
                else lerr = 1;
            end
        endcase
    endfunction

    function automatic void finish_line();
        parse_result_t r;
        if (lerr) begin
            push_bad(ERR_MALFORMED);
            return;
        end
        case (phase)
            PH_VERSION: if (pos != 9) begin
                push_bad(ERR_MALFORMED);
                return;
            end
            PH_NAME: begin
                if (pos != 0) begin
                    push_bad(ERR_MALFORMED);
                    return;
                end
                r = '0; r.kind = KIND_DONE; r.method_code = mheld; r.path_valid = pok;
                r.close_requested = seen[0] && cmatch == 5;
                clear_parse();
                expected_results.push_back(r);
                return;
            end
            PH_VALUE, PH_TRAIL: begin
                if ((cand & seen) != 0 || (cand[2] && ldig != LD_ZERO)) begin
                    push_bad(ERR_MALFORMED);
                    return;
                end
                seen |= cand;
            end
            default: begin
                push_bad(ERR_MALFORMED);
                return;
            end
        endcase
        phase = PH_NAME; pos = 0; cand = 4'hF;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic nc);
        if (nc) clear_parse();
        if (prev_cr && b == CH_LF) begin
            prev_cr = 0; line_count = 0;
            finish_line();
            return;
        end
        if (line_count < 65535) line_count++;
        if (line_count > line_limit) begin
            push_bad(ERR_TOO_LONG);
            return;
        end
        if (phase >= PH_NAME) begin
            if (prev_cr) begin
                prev_cr = 0;
                track_header(CH_CR);
            end
            if (b == CH_CR) prev_cr = 1;
            else track_header(b);
            return;
        end
        prev_cr = (b == CH_CR);
        track_start(b);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // The request stays offered after acceptance until the next one replaces it
    // or an idle gap or a drain takes s_tvalid low.
    task automatic send_request(logic [7:0] b, logic nc);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1; s_tdata <= b; s_tuser <= nc;
        do @(posedge aclk); while (!s_tready);
        predict_byte(b, nc);
        @(negedge aclk);
    endtask

    task automatic send_text(string s, logic nc_first);
        for (int i = 0; i < s.len(); i++) send_request(s[i], nc_first && i == 0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(logic [15:0] v);
        drain();
        cfg_wr_en <= 1'b1; cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        line_limit = v;
    endtask

    function automatic string random_token(int n, bit clean);
        string s, pool;
        pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-./";
        s = "";
        for (int i = 0; i < n; i++) begin
            if (clean || $urandom_range(0, 9) != 0) s = {s, string'(pool[$urandom_range(0, 64)])};
            else s = {s, string'(8'($urandom_range(33, 255)))};
        end
        return s;
    endfunction

    function automatic string random_case(string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1)) r[i] = r[i] - 8'd32;
        return r;
    endfunction

    function automatic string random_request();
        string s, hdrs[$], m, v;
        int k;
        case ($urandom_range(0, 3))
            0: m = "GET";
            1: m = "HEAD";
            2: m = "GE";
            default: m = random_token($urandom_range(1, 6), 1);
        endcase
        s = {m, " /", random_token($urandom_range(0, 8), $urandom_range(0, 2) != 0),
             " HTTP/1.1\r\n"};
        repeat ($urandom_range(0, 4)) begin
            k = $urandom_range(0, 4);
            case (k)
                0: v = $urandom_range(0, 2) ? "close" : "keep-alive";
                2: v = $urandom_range(0, 3) ? "0" : ($urandom_range(0, 1) ? "00" : "12");
                default: v = random_token($urandom_range(1, 6), 1);
            endcase
            if (k == 4) hdrs.push_back({random_token($urandom_range(1, 9), 1), ": ", v});
            else hdrs.push_back({random_case(txt_hdr[k]), ":", $urandom_range(0, 1) ? " " : "",
                                 v, $urandom_range(0, 3) ? "" : " "});
        end
        foreach (hdrs[i]) s = {s, hdrs[i], "\r\n"};
        s = {s, "\r\n"};
        // Occasionally corrupt one byte.
        if ($urandom_range(0, 7) == 0) s[$urandom_range(0, s.len() - 1)] = 8'($urandom);
        return s;
    endfunction

    // Result checker.
    always @(posedge aclk) begin
        parse_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result kind", m_tuser, -1);
            end else begin
                want = expected_results.pop_front();
                if (m_tuser != want.kind) report_mismatch("kind", m_tuser, want.kind);
                if (m_tdata[7:0] != want.path_byte)
                    report_mismatch("path_byte", m_tdata[7:0], want.path_byte);
                if (m_tdata[9:8] != want.method_code)
                    report_mismatch("method_code", m_tdata[9:8], want.method_code);
                if (m_tdata[10] != want.path_valid)
                    report_mismatch("path_valid", m_tdata[10], want.path_valid);
                if (m_tdata[11] != want.close_requested)
                    report_mismatch("close_requested", m_tdata[11], want.close_requested);
                if (m_tdata[13:12] != want.error_cause)
                    report_mismatch("error_cause", m_tdata[13:12], want.error_cause);
            end
        end
    end

    // Sink side readiness with random stalls and one long hold-off.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (60) @(negedge aclk);
                hold_sink = 0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    stim_row_t directed[$];

    task automatic add_row(logic [7:0] b, logic nc, logic fx, logic [1:0] k, logic [1:0] e);
        stim_row_t r;
        r.data_byte = b; r.new_conn = nc; r.has_fixed = fx; r.fixed_kind = k; r.fixed_err = e;
        directed.push_back(r);
    endtask

    initial begin
        string req;
        int n;
        line_limit = 8192;
        clear_parse();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table: extreme bytes, a space at start of line, lone CR, new connection.
        add_row(8'h00, 1'b1, 0, 0, 0);
        add_row(8'hFF, 1'b0, 0, 0, 0);
        add_row(CH_CR, 1'b0, 0, 0, 0);
        add_row(CH_LF, 1'b0, 1, KIND_BAD, ERR_MALFORMED);
        add_row(" ", 1'b0, 0, 0, 0);
        add_row(CH_CR, 1'b0, 0, 0, 0);
        add_row(CH_LF, 1'b0, 1, KIND_BAD, ERR_MALFORMED);
        add_row("G", 1'b0, 0, 0, 0);
        add_row(" ", 1'b0, 0, 0, 0);
        add_row("/", 1'b0, 0, 0, 0);
        add_row(CH_CR, 1'b0, 0, 0, 0);
        add_row("x", 1'b1, 0, 0, 0);
        add_row(CH_CR, 1'b0, 0, 0, 0);
        add_row(CH_LF, 1'b0, 1, KIND_BAD, ERR_MALFORMED);
        foreach (directed[i]) begin
            n = expected_results.size();
            send_request(directed[i].data_byte, directed[i].new_conn);
            if (directed[i].has_fixed && (expected_results.size() != n + 1 ||
                expected_results[$].kind != directed[i].fixed_kind ||
                expected_results[$].error_cause != directed[i].fixed_err))
                report_mismatch("directed row", i, directed[i].fixed_kind);
        end
        send_text("GET /index.html HTTP/1.1\r\nConnection: close\r\n"
                  , 1'b1);
        send_text("CONTENT-LENGTH: 000 \r\nserver: x\r\nContent-Type: a\r\n\r\n", 1'b0);
        send_text("HEAD /a%b HTTP/1.1\r\ncontent-length:5\r\n", 1'b0);
        send_text("PUT /\rz HTTP/1.1\r\nconnection: close\r\nConnection: x\r\n", 1'b0);
        send_text("GET / HTTP/1.1\r\ncontent-length: \r\nconnection:  Close\r\n\r\n", 1'b1);

        write_limit(16'd16);
        send_text("GET /abcdefghijklmnop HTTP/1.1\r\n", 1'b1);
        send_text("GET /x HTTP/1.1\r\nserver: 0123456789\r\n\r\n", 1'b1);
        write_limit(16'd65535);
        // Long stall on the sink while the source keeps offering path bytes.
        hold_sink = 1;
        send_text({"GET /", random_token(200, 1), " HTTP/1.1\r\n\r\n"}, 1'b1);

        n = 0;
        while (n < 1400) begin
            if (n > 450 && n < 500) write_limit($urandom_range(0, 1) ? 16'd20 : 16'd40);
            if (n > 900 && n < 950) write_limit(16'd8192);
            if (n > 1150) no_idle = 1;
            if ($urandom_range(0, 9) == 0) req = random_token($urandom_range(1, 30), 0);
            else req = random_request();
            send_text(req, $urandom_range(0, 6) == 0);
            n += req.len();
        end
        drain();
        repeat (10) @(negedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

[http_request_head_parser.f]
hw/rtl/hrhp_pkg.sv
hw/rtl/hrhp_step.sv
hw/rtl/http_request_head_parser.sv
tb/tb.sv
